@@ rtl/scl_pkg.sv @@
// shared types, codes and character constants for the integer literal scanner
`default_nettype none

package scl_pkg;

  // width of the value field on the result channel
  localparam int unsigned VALUE_BITS = 64;

  // digit code width and the code for a character that is no digit
  localparam int unsigned DIGIT_BITS = 5;
  localparam logic [DIGIT_BITS-1:0] NO_DIGIT = 5'd16;

  // radix values
  localparam logic [DIGIT_BITS-1:0] RADIX_VAL_DEC = 5'd10;
  localparam logic [DIGIT_BITS-1:0] RADIX_VAL_OCT = 5'd8;
  localparam logic [DIGIT_BITS-1:0] RADIX_VAL_HEX = 5'd16;

  // characters with a meaning of their own
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LOW_X   = 8'h78;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_LOW_U   = 8'h75;
  localparam logic [7:0] CH_UP_U    = 8'h55;
  localparam logic [7:0] CH_LOW_L   = 8'h6c;
  localparam logic [7:0] CH_UP_L    = 8'h4c;

  // position counter saturates here
  localparam logic [1:0] POS_SAT = 2'd2;

  // result status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_MALFORMED = 1'b1;

  // scan phase of the current literal
  typedef enum logic [2:0] {
    PH_DIGITS = 3'd0,
    PH_UFIRST = 3'd1,
    PH_LONE   = 3'd2,
    PH_LTWO   = 3'd3,
    PH_CLOSED = 3'd4
  } phase_e;

  // number base of the current literal
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  // control state carried from character to character
  typedef struct packed {
    phase_e     phase;
    radix_e     radix;
    logic [1:0] position;
    logic       seen_digit;
    logic       unsigned_flag;
    logic       long_upper;
    logic       failed;
  } scan_state_t;

  localparam scan_state_t SCAN_STATE_RESET = '{
    phase:         PH_DIGITS,
    radix:         RADIX_DEC,
    position:      2'd0,
    seen_digit:    1'b0,
    unsigned_flag: 1'b0,
    long_upper:    1'b0,
    failed:        1'b0
  };

  // status flags of one result item
  typedef struct packed {
    logic status;
    logic uns_flag;
  } scan_flags_t;

  // digit value of a character, NO_DIGIT when it is none
  function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [7:0] c);
    logic [DIGIT_BITS-1:0] d;
    d = NO_DIGIT;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = {1'b0, c[3:0]};
    end else if (c inside {[CH_LOW_A:CH_LOW_F], [CH_UP_A:CH_UP_F]}) begin
      d = {1'b0, c[3:0]} + 5'd9;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/scl_char_if.sv @@
// character channel: one literal character per item with a last mark
`default_nettype none

interface scl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

@@ rtl/scl_result_if.sv @@
// result channel: status, value and unsigned flag of one literal per item
`default_nettype none

interface scl_result_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic [scl_pkg::VALUE_BITS-1:0]  value;
  logic                            uns_flag;

  modport source (output valid, output status, output value, output uns_flag, input ready);
  modport sink   (input valid, input status, input value, input uns_flag, output ready);
endinterface

`default_nettype wire

@@ rtl/c_integer_literal_scanner_unit.sv @@
// top level of the C integer literal scanner: input register, scan logic, result register
//
// Usage: characters of one C integer literal arrive on in_i, one per item,
// with last_char set on the final one. Each literal gives exactly one item
// on out_o when its last character has been scanned: status (0 ok,
// 1 malformed), the value zero-extended to 64 bits (zero when malformed) and
// the unsigned flag. Items without last_char give no result.
// Path: a character accepted into the input register is scanned from there by
// combinational logic, and a literal's result is captured in the output
// register when its last character is scanned.
// Throughput: one character per cycle while no last character waits, set by
// the combinational shift-add and overflow check of the fed-back accumulator.
// Reset: rst_ni clears the input and output valid flags and the scan state,
// so the next character starts a new literal.
// Stall: while out_o is held, characters without last_char keep being
// scanned; a last character waits in the input register until the pending
// result is taken, and in_i.ready drops while it waits.
`default_nettype none

module c_integer_literal_scanner_unit #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  scl_char_if.sink        in_i,
  scl_result_if.source    out_o
);

  logic                            s0_valid_q;
  logic [7:0]                      s0_char_q;
  logic                            s0_last_q;
  logic                            process;
  scl_pkg::scan_state_t            state_q;
  scl_pkg::scan_state_t            state_d;
  logic [VALUE_WIDTH-1:0]          acc_q;
  logic [VALUE_WIDTH-1:0]          acc_d;
  scl_pkg::scan_flags_t            flags;
  logic [scl_pkg::VALUE_BITS-1:0]  value;
  logic                            out_valid_q;
  scl_pkg::scan_flags_t            out_flags_q;
  logic [scl_pkg::VALUE_BITS-1:0]  out_value_q;

  // scan the held character when its result, if any, has room
  assign process  = s0_valid_q && (!s0_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s0_valid_q || process;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s0_char_q <= in_i.char_code;
      s0_last_q <= in_i.last_char;
    end
  end

  // scan logic
  scl_step #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_step (
    .char_code_i (s0_char_q),
    .last_char_i (s0_last_q),
    .state_i     (state_q),
    .acc_i       (acc_q),
    .state_o     (state_d),
    .acc_o       (acc_d),
    .flags_o     (flags),
    .value_o     (value)
  );

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scl_pkg::SCAN_STATE_RESET;
      acc_q   <= '0;
    end else if (process) begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process && s0_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && s0_last_q) begin
      out_flags_q <= flags;
      out_value_q <= value;
    end
  end

  // result channel
  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_flags_q.status;
  assign out_o.value    = out_value_q;
  assign out_o.uns_flag = out_flags_q.uns_flag;

endmodule

`default_nettype wire

@@ rtl/scl_step.sv @@
// next-state and result logic for one character of a literal
`default_nettype none

module scl_step #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic [7:0]                      char_code_i,
  input  logic                            last_char_i,
  input  scl_pkg::scan_state_t            state_i,
  input  logic [VALUE_WIDTH-1:0]          acc_i,
  output scl_pkg::scan_state_t            state_o,
  output logic [VALUE_WIDTH-1:0]          acc_o,
  output scl_pkg::scan_flags_t            flags_o,
  output logic [scl_pkg::VALUE_BITS-1:0]  value_o
);

  localparam int unsigned WideBits = VALUE_WIDTH + 5;

  scl_pkg::scan_state_t            nxt;
  logic [VALUE_WIDTH-1:0]          acc_nxt;
  scl_pkg::radix_e                 radix_w;
  logic [scl_pkg::DIGIT_BITS-1:0]  radix_val;
  logic [scl_pkg::DIGIT_BITS-1:0]  digit;
  logic [WideBits-1:0]             acc_wide;
  logic [WideBits-1:0]             scaled;
  logic [WideBits-1:0]             sum;
  logic                            ovf;
  logic                            is_u;
  logic                            is_l;
  logic                            is_x;
  logic                            bad;
  logic                            uns;

  // character classes
  assign is_u  = (char_code_i == scl_pkg::CH_LOW_U) || (char_code_i == scl_pkg::CH_UP_U);
  assign is_l  = (char_code_i == scl_pkg::CH_LOW_L) || (char_code_i == scl_pkg::CH_UP_L);
  assign is_x  = (char_code_i == scl_pkg::CH_LOW_X) || (char_code_i == scl_pkg::CH_UP_X);
  assign digit = scl_pkg::digit_of(char_code_i);

  // leading zero switches to octal before the digit is judged
  always_comb begin
    radix_w = state_i.radix;
    if (state_i.position == 2'd0 && char_code_i == scl_pkg::CH_ZERO) begin
      radix_w = scl_pkg::RADIX_OCT;
    end
  end

  // radix as a number and accumulator times radix by shifts
  assign acc_wide = {5'b0, acc_i};
  always_comb begin
    case (radix_w)
      scl_pkg::RADIX_HEX: begin
        radix_val = scl_pkg::RADIX_VAL_HEX;
        scaled    = acc_wide << 4;
      end
      scl_pkg::RADIX_OCT: begin
        radix_val = scl_pkg::RADIX_VAL_OCT;
        scaled    = acc_wide << 3;
      end
      default: begin
        radix_val = scl_pkg::RADIX_VAL_DEC;
        scaled    = (acc_wide << 3) + (acc_wide << 1);
      end
    endcase
  end

  // add the digit and flag anything beyond the value width
  assign sum = scaled + WideBits'(digit);
  assign ovf = |sum[WideBits-1:VALUE_WIDTH];

  // character handling by phase
  always_comb begin
    nxt     = state_i;
    acc_nxt = acc_i;
    if (!state_i.failed) begin
      case (state_i.phase)
        scl_pkg::PH_DIGITS: begin
          nxt.radix = radix_w;
          if (state_i.position == 2'd1 && radix_w == scl_pkg::RADIX_OCT && is_x) begin
            nxt.radix      = scl_pkg::RADIX_HEX;
            nxt.seen_digit = 1'b0;
            acc_nxt        = '0;
          end else if (digit < radix_val) begin
            nxt.seen_digit = 1'b1;
            if (ovf) begin
              nxt.failed = 1'b1;
            end else begin
              acc_nxt = sum[VALUE_WIDTH-1:0];
            end
          end else if (!state_i.seen_digit) begin
            nxt.failed = 1'b1;
          end else if (is_u) begin
            nxt.unsigned_flag = 1'b1;
            nxt.phase         = scl_pkg::PH_UFIRST;
          end else if (is_l) begin
            nxt.long_upper = (char_code_i == scl_pkg::CH_UP_L);
            nxt.phase      = scl_pkg::PH_LONE;
          end else begin
            nxt.failed = 1'b1;
          end
        end
        scl_pkg::PH_UFIRST: begin
          if (is_l) begin
            nxt.long_upper = (char_code_i == scl_pkg::CH_UP_L);
            nxt.phase      = scl_pkg::PH_LONE;
          end else begin
            nxt.failed = 1'b1;
          end
        end
        scl_pkg::PH_LONE: begin
          if (char_code_i == (state_i.long_upper ? scl_pkg::CH_UP_L : scl_pkg::CH_LOW_L)) begin
            nxt.phase = scl_pkg::PH_LTWO;
          end else if (is_u && !state_i.unsigned_flag) begin
            nxt.unsigned_flag = 1'b1;
            nxt.phase         = scl_pkg::PH_CLOSED;
          end else begin
            nxt.failed = 1'b1;
          end
        end
        scl_pkg::PH_LTWO: begin
          if (is_u && !state_i.unsigned_flag) begin
            nxt.unsigned_flag = 1'b1;
            nxt.phase         = scl_pkg::PH_CLOSED;
          end else begin
            nxt.failed = 1'b1;
          end
        end
        default: begin
          nxt.failed = 1'b1;
        end
      endcase
    end
    if (state_i.position != scl_pkg::POS_SAT) begin
      nxt.position = state_i.position + 2'd1;
    end
  end

  // result of a literal ending on this character
  always_comb begin
    bad = nxt.failed || !nxt.seen_digit;
    uns = nxt.unsigned_flag;
    if (!bad && !uns && acc_nxt[VALUE_WIDTH-1]) begin
      if (nxt.radix == scl_pkg::RADIX_DEC) begin
        bad = 1'b1;
      end else begin
        uns = 1'b1;
      end
    end
  end

  assign flags_o.status   = bad ? scl_pkg::STATUS_MALFORMED : scl_pkg::STATUS_OK;
  assign flags_o.uns_flag = !bad && uns;
  assign value_o          = bad ? '0 : scl_pkg::VALUE_BITS'(acc_nxt);

  // the last character returns the scanner to its start
  assign state_o = last_char_i ? scl_pkg::SCAN_STATE_RESET : nxt;
  assign acc_o   = last_char_i ? '0 : acc_nxt;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the c integer literal scanner unit
`default_nettype none

module tb;

  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned CHAR_TARGET = 1350;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_PCT = 32;
  localparam int unsigned N_DIR = 14;

  // one result item as seen on the result channel
  typedef struct packed {
    logic                           status;
    logic [scl_pkg::VALUE_BITS-1:0] value;
    logic                           is_uns;
  } lit_result_t;

  // scan state of the literal in progress, all zero when idle
  typedef struct packed {
    scl_pkg::phase_e        ph;
    scl_pkg::radix_e        rdx;
    logic [VALUE_WIDTH-1:0] acc;
    logic [1:0]             pos;
    logic                   seen;
    logic                   uflag;
    logic                   lupper;
    logic                   failed;
  } lit_state_t;

  // one character item with its typed expectation, if any
  typedef struct {
    logic [7:0]  ch;
    bit          last;
    bit          typed;
    lit_result_t want;
  } chr_item_t;

  // directed literal with an optional typed result
  typedef struct {
    string       text;
    bit          typed;
    logic        status;
    logic [63:0] value;
    logic        uns;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  scl_char_if   chr_if ();
  scl_result_if res_if ();

  c_integer_literal_scanner_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (chr_if),
    .out_o (res_if)
  );

  chr_item_t   stim_q[$];
  lit_result_t want_q[$];
  logic [7:0]  txt[$];
  lit_state_t  lit;

  int unsigned feed_idx = 0;
  int unsigned taken = 0;
  int unsigned cyc = 0;
  int unsigned errs = 0;
  int unsigned n_lits = 0;
  int unsigned n_ok = 0;
  int unsigned n_bad = 0;
  int unsigned n_uns = 0;

  dir_row_t dir_tab [N_DIR] = '{
    '{"0",     1, scl_pkg::STATUS_OK,        64'd0,  1'b0},
    '{"7",     1, scl_pkg::STATUS_OK,        64'd7,  1'b0},
    '{"0x",    1, scl_pkg::STATUS_MALFORMED, 64'd0,  1'b0},
    '{"0XaF",  0, scl_pkg::STATUS_OK,        64'd0,  1'b0},
    '{"08",    1, scl_pkg::STATUS_MALFORMED, 64'd0,  1'b0},
    '{"12uLL", 1, scl_pkg::STATUS_OK,        64'd12, 1'b1},
    '{"3lu",   1, scl_pkg::STATUS_OK,        64'd3,  1'b1},
    '{"5Ll",   1, scl_pkg::STATUS_MALFORMED, 64'd0,  1'b0},
    '{"6uu",   1, scl_pkg::STATUS_MALFORMED, 64'd0,  1'b0},
    '{"9llU",  0, scl_pkg::STATUS_OK,        64'd0,  1'b0},
    '{"u",     1, scl_pkg::STATUS_MALFORMED, 64'd0,  1'b0},
    '{"\377",  1, scl_pkg::STATUS_MALFORMED, 64'd0,  1'b0},
    '{"4L",    0, scl_pkg::STATUS_OK,        64'd0,  1'b0},
    '{"017",   0, scl_pkg::STATUS_OK,        64'd0,  1'b0}
  };

  string extreme_tab [10] = '{
    "18446744073709551615", "18446744073709551616", "9223372036854775807",
    "9223372036854775808", "0xFFFFFFFFFFFFFFFF", "0x10000000000000000",
    "01777777777777777777777", "02000000000000000000000", "0x8000000000000000",
    "0777777777777777777777"
  };

  string good_sfx [20] = '{
    "", "", "", "", "u", "U", "l", "L", "ll", "LL", "ul", "uL", "Ul", "ULL",
    "ull", "lu", "lU", "Lu", "llu", "LLU"
  };

  string bad_sfx [10] = '{
    "lL", "Ll", "uu", "lul", "ulu", "lll", "LLL", "uLu", "x", "lLu"
  };

  // clock and reset
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    chr_if.valid = 1'b0;
    chr_if.char_code = 8'h00;
    chr_if.last_char = 1'b0;
    res_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // digit value of a character, NO_DIGIT when it is none
  function automatic logic [scl_pkg::DIGIT_BITS-1:0] char_val(input logic [7:0] c);
    if (c >= scl_pkg::CH_ZERO && c <= scl_pkg::CH_NINE)
      return scl_pkg::DIGIT_BITS'(c - scl_pkg::CH_ZERO);
    if (c >= scl_pkg::CH_LOW_A && c <= scl_pkg::CH_LOW_F)
      return scl_pkg::DIGIT_BITS'(c - scl_pkg::CH_LOW_A + 8'd10);
    if (c >= scl_pkg::CH_UP_A && c <= scl_pkg::CH_UP_F)
      return scl_pkg::DIGIT_BITS'(c - scl_pkg::CH_UP_A + 8'd10);
    return scl_pkg::NO_DIGIT;
  endfunction

  function automatic bit is_u_char(input logic [7:0] c);
    return c == scl_pkg::CH_LOW_U || c == scl_pkg::CH_UP_U;
  endfunction

  function automatic bit is_l_char(input logic [7:0] c);
    return c == scl_pkg::CH_LOW_L || c == scl_pkg::CH_UP_L;
  endfunction

  // literal scanner: steps the state by one character, returns 1 with a result on the last
  function automatic bit scan_char(input logic [7:0] c, input bit last_c,
                                   output lit_result_t res);
    logic [VALUE_WIDTH-1:0] vmax;
    logic [VALUE_WIDTH-1:0] r;
    logic [VALUE_WIDTH-1:0] d;
    bit bad;
    bit uns;
    vmax = '1;
    res = '0;
    if (!lit.failed) begin
      case (lit.ph)
        scl_pkg::PH_DIGITS: begin
          if (lit.pos == 2'd0 && c == scl_pkg::CH_ZERO) lit.rdx = scl_pkg::RADIX_OCT;
          if (lit.pos == 2'd1 && lit.rdx == scl_pkg::RADIX_OCT &&
              (c == scl_pkg::CH_LOW_X || c == scl_pkg::CH_UP_X)) begin
            // prefix 0x: restart digits in hex
            lit.rdx = scl_pkg::RADIX_HEX;
            lit.seen = 1'b0;
            lit.acc = '0;
          end else begin
            case (lit.rdx)
              scl_pkg::RADIX_HEX: r = VALUE_WIDTH'(scl_pkg::RADIX_VAL_HEX);
              scl_pkg::RADIX_OCT: r = VALUE_WIDTH'(scl_pkg::RADIX_VAL_OCT);
              default:            r = VALUE_WIDTH'(scl_pkg::RADIX_VAL_DEC);
            endcase
            d = VALUE_WIDTH'(char_val(c));
            if (d < r) begin
              lit.seen = 1'b1;
              if (lit.acc > (vmax - d) / r) lit.failed = 1'b1;
              else lit.acc = lit.acc * r + d;
            end else if (!lit.seen) begin
              lit.failed = 1'b1;
            end else if (is_u_char(c)) begin
              lit.uflag = 1'b1;
              lit.ph = scl_pkg::PH_UFIRST;
            end else if (is_l_char(c)) begin
              lit.lupper = (c == scl_pkg::CH_UP_L);
              lit.ph = scl_pkg::PH_LONE;
            end else begin
              lit.failed = 1'b1;
            end
          end
        end
        scl_pkg::PH_UFIRST: begin
          if (is_l_char(c)) begin
            lit.lupper = (c == scl_pkg::CH_UP_L);
            lit.ph = scl_pkg::PH_LONE;
          end else begin
            lit.failed = 1'b1;
          end
        end
        scl_pkg::PH_LONE: begin
          if (c == (lit.lupper ? scl_pkg::CH_UP_L : scl_pkg::CH_LOW_L)) begin
            lit.ph = scl_pkg::PH_LTWO;
          end else if (is_u_char(c) && !lit.uflag) begin
            lit.uflag = 1'b1;
            lit.ph = scl_pkg::PH_CLOSED;
          end else begin
            lit.failed = 1'b1;
          end
        end
        scl_pkg::PH_LTWO: begin
          if (is_u_char(c) && !lit.uflag) begin
            lit.uflag = 1'b1;
            lit.ph = scl_pkg::PH_CLOSED;
          end else begin
            lit.failed = 1'b1;
          end
        end
        default: lit.failed = 1'b1;
      endcase
    end
    if (lit.pos < scl_pkg::POS_SAT) lit.pos = lit.pos + 2'd1;
    if (!last_c) return 1'b0;
    // closing check: range against the signed maximum
    bad = lit.failed || !lit.seen;
    uns = lit.uflag;
    if (!bad && !uns && lit.acc > (vmax >> 1)) begin
      if (lit.rdx == scl_pkg::RADIX_DEC) bad = 1'b1;
      else uns = 1'b1;
    end
    res.status = bad ? scl_pkg::STATUS_MALFORMED : scl_pkg::STATUS_OK;
    res.value = bad ? '0 : scl_pkg::VALUE_BITS'(lit.acc);
    res.is_uns = !bad && uns;
    lit = '0;
    return 1'b1;
  endfunction

  // literal text building
  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endtask

  task automatic put_lit(input bit typed, input lit_result_t want);
    chr_item_t it;
    for (int i = 0; i < txt.size(); i++) begin
      it.ch = txt[i];
      it.last = (i == txt.size() - 1);
      it.typed = typed && it.last;
      it.want = want;
      stim_q.push_back(it);
    end
    txt.delete();
  endtask

  function automatic logic [7:0] hex_char(input int unsigned v);
    if (v < 10) return scl_pkg::CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? scl_pkg::CH_LOW_A : scl_pkg::CH_UP_A) + 8'(v - 10);
  endfunction

  // well-formed digits in a random radix, mostly short
  task automatic put_digits();
    int unsigned ndig;
    int unsigned rsel;
    ndig = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 5) : $urandom_range(6, 23);
    rsel = $urandom_range(0, 2);
    if (rsel == 0) begin
      txt.push_back(scl_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
      for (int i = 1; i < ndig; i++) txt.push_back(scl_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (rsel == 1) begin
      txt.push_back(scl_pkg::CH_ZERO);
      for (int i = 1; i < ndig; i++) txt.push_back(scl_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
    end else begin
      txt.push_back(scl_pkg::CH_ZERO);
      txt.push_back($urandom_range(0, 1) ? scl_pkg::CH_LOW_X : scl_pkg::CH_UP_X);
      for (int i = 0; i < ndig; i++) txt.push_back(hex_char($urandom_range(0, 15)));
    end
  endtask

  // stimulus: directed table, then random literals
  task automatic build_stim();
    lit_result_t want;
    int unsigned kind;
    int unsigned n;
    for (int i = 0; i < N_DIR; i++) begin
      want = '{status: dir_tab[i].status, value: dir_tab[i].value, is_uns: dir_tab[i].uns};
      put_str(dir_tab[i].text);
      put_lit(dir_tab[i].typed, want);
    end
    while (stim_q.size() < CHAR_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        put_str(extreme_tab[$urandom_range(0, 9)]);
        put_str(good_sfx[$urandom_range(0, 19)]);
      end else if (kind < 75) begin
        put_digits();
        put_str(good_sfx[$urandom_range(0, 19)]);
      end else if (kind < 90) begin
        // broken: a stray character or a bad suffix
        put_digits();
        put_str(good_sfx[$urandom_range(0, 19)]);
        if ($urandom_range(0, 1)) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
        else put_str(bad_sfx[$urandom_range(0, 9)]);
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) txt.push_back(8'($urandom_range(0, 255)));
      end
      put_lit(1'b0, '0);
    end
  endtask

  // character source with random gaps, none in a middle stretch
  always @(posedge clk_i) begin
    if (rst_ni && (!chr_if.valid || chr_if.ready)) begin
      if (feed_idx < stim_q.size() &&
          ((feed_idx >= 500 && feed_idx < 800) || $urandom_range(0, 99) >= IDLE_PCT)) begin
        chr_if.valid <= 1'b1;
        chr_if.char_code <= stim_q[feed_idx].ch;
        chr_if.last_char <= stim_q[feed_idx].last;
        feed_idx <= feed_idx + 1;
      end else begin
        chr_if.valid <= 1'b0;
      end
    end
  end

  // result sink with random stalls, none in the same middle stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      res_if.ready <= (feed_idx >= 500 && feed_idx < 800) ||
                      ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic report(input string what, input lit_result_t exp, input lit_result_t got);
    errs++;
    if (errs <= 10) begin
      $display("mismatch: %s: exp status %0d value %h uns %0d, got status %0d value %h uns %0d",
               what, exp.status, exp.value, exp.is_uns, got.status, got.value, got.is_uns);
    end
  endtask

  // predict on accepted characters, compare accepted results
  always @(posedge clk_i) begin
    lit_result_t got;
    lit_result_t calc;
    lit_result_t exp;
    chr_item_t it;
    if (rst_ni) begin
      if (chr_if.valid && chr_if.ready) begin
        it = stim_q[taken];
        taken++;
        if (scan_char(it.ch, it.last, calc)) want_q.push_back(it.typed ? it.want : calc);
      end
      if (res_if.valid && res_if.ready) begin
        got = '{status: res_if.status, value: res_if.value, is_uns: res_if.uns_flag};
        n_lits++;
        if (got.status == scl_pkg::STATUS_OK) n_ok++;
        else n_bad++;
        if (got.is_uns) n_uns++;
        if (want_q.size() == 0) begin
          report("result with no literal pending", '0, got);
        end else begin
          exp = want_q.pop_front();
          if (got.status !== exp.status || got.value !== exp.value ||
              got.is_uns !== exp.is_uns) begin
            report("literal result", exp, got);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cyc++;
    if (cyc >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d literals pending", cyc, want_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // main sequence and final verdict
  initial begin
    lit = '0;
    build_stim();
    while (taken < stim_q.size() || want_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("scanned %0d characters into %0d literals in %0d cycles",
             taken, n_lits, cyc);
    $display("%0d ok (%0d unsigned), %0d malformed, %0d mismatches",
             n_ok, n_uns, n_bad, errs);
    if (errs == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
